// File: rtl/ird_pkg.sv
// Shared types and constants of the IDEA round datapath.
`timescale 1ns / 1ps

package ird_pkg;

    localparam int WORD_W = 16;
    localparam int PROD_W = 2 * WORD_W + 1;

    localparam logic OP_ROUND  = 1'b0;
    localparam logic OP_OUTPUT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
        logic [WORD_W-1:0] key_mul_first;
        logic [WORD_W-1:0] key_add_second;
        logic [WORD_W-1:0] key_add_third;
        logic [WORD_W-1:0] key_mul_last;
        logic [WORD_W-1:0] key_mix_first;
        logic [WORD_W-1:0] key_mix_second;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] out_a;
        logic [WORD_W-1:0] out_b;
        logic [WORD_W-1:0] out_c;
        logic [WORD_W-1:0] out_d;
    } t_out_item;

endpackage

// File: rtl/ird_mul_stage.sv
// Registered 17x17 multiply of two IDEA words, with zero standing for 65536.
`timescale 1ns / 1ps

module ird_mul_stage (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ird_pkg::WORD_W-1:0]  i_x,
    input  logic [ird_pkg::WORD_W-1:0]  i_y,
    output logic [ird_pkg::PROD_W-1:0]  o_prod
);

    logic [ird_pkg::WORD_W:0]   w_x;
    logic [ird_pkg::WORD_W:0]   w_y;
    logic [ird_pkg::PROD_W-1:0] n_prod;
    logic [ird_pkg::PROD_W-1:0] r_prod;

    always_comb begin
        w_x    = (i_x == '0) ? {1'b1, {ird_pkg::WORD_W{1'b0}}} : {1'b0, i_x};
        w_y    = (i_y == '0) ? {1'b1, {ird_pkg::WORD_W{1'b0}}} : {1'b0, i_y};
        n_prod = ird_pkg::PROD_W'(w_x * w_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/idea_round_datapath.sv
// Top level of the pipelined IDEA round datapath.
//
// One IDEA round, or the output transformation alone, on a 64-bit block.
// The input channel (i_in_valid, i_in_data, o_in_stall) carries the four data
// words, the six subkeys and the operation of one block per transfer. The
// output channel (o_out_valid, o_out_data, i_out_stall) returns the four result
// words of each block, in the order the blocks came in.
// The datapath is six register stages deep: the four modulo 65537
// multiplications, in three chained levels, each take one stage for the
// product and one for the reduction. One block can be taken in every cycle
// unless the input is stalled.
// Each stage moves forward whenever it is empty or the stage after it moves,
// so empty slots close up while the receiver stalls. The input stalls only
// when all six stages hold blocks and the output is stalled.
// Synchronous active-low reset empties the pipeline; no result is lost or
// repeated across a stall.
`timescale 1ns / 1ps

module idea_round_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ird_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output ird_pkg::t_out_item o_out_data,
    input  logic              i_out_stall
);

    localparam int NSTG = 6;
    localparam int W    = ird_pkg::WORD_W;

    function automatic logic [W-1:0] mod_reduce(input logic [ird_pkg::PROD_W-1:0] p);
        logic [W+1:0] diff;
        diff = {2'b00, p[W-1:0]} - {1'b0, p[ird_pkg::PROD_W-1:W]};
        if (diff[W+1]) begin
            diff = diff + (W+2)'((1 << W) + 1);
        end
        return diff[W-1:0];
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !w_adv[0];
    assign o_out_valid = r_vld[NSTG-1];

    // Stage 0: half-round products and additions.
    logic [ird_pkg::PROD_W-1:0] w0_pa;
    logic [ird_pkg::PROD_W-1:0] w0_pd;
    logic         r0_op;
    logic [W-1:0] r0_hb, r0_hc, r0_k5, r0_k6;

    ird_mul_stage u_mul_a (
        .i_clk  (i_clk),
        .i_en   (w_adv[0]),
        .i_x    (i_in_data.word_a),
        .i_y    (i_in_data.key_mul_first),
        .o_prod (w0_pa)
    );

    ird_mul_stage u_mul_d (
        .i_clk  (i_clk),
        .i_en   (w_adv[0]),
        .i_x    (i_in_data.word_d),
        .i_y    (i_in_data.key_mul_last),
        .o_prod (w0_pd)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_op <= i_in_data.operation;
            r0_hb <= i_in_data.word_c + i_in_data.key_add_second;
            r0_hc <= i_in_data.word_b + i_in_data.key_add_third;
            r0_k5 <= i_in_data.key_mix_first;
            r0_k6 <= i_in_data.key_mix_second;
        end
    end

    // Stage 1: reduce the half-round products, form the mixing inputs.
    logic [W-1:0] n1_ha, n1_hd;
    logic         r1_op;
    logic [W-1:0] r1_ha, r1_hb, r1_hc, r1_hd, r1_p, r1_q, r1_k5, r1_k6;

    assign n1_ha = mod_reduce(w0_pa);
    assign n1_hd = mod_reduce(w0_pd);

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_op <= r0_op;
            r1_ha <= n1_ha;
            r1_hb <= r0_hb;
            r1_hc <= r0_hc;
            r1_hd <= n1_hd;
            r1_p  <= n1_ha ^ r0_hb;
            r1_q  <= r0_hc ^ n1_hd;
            r1_k5 <= r0_k5;
            r1_k6 <= r0_k6;
        end
    end

    // Stage 2: first mixing product.
    logic [ird_pkg::PROD_W-1:0] w2_ps;
    logic         r2_op;
    logic [W-1:0] r2_ha, r2_hb, r2_hc, r2_hd, r2_q, r2_k6;

    ird_mul_stage u_mul_s (
        .i_clk  (i_clk),
        .i_en   (w_adv[2]),
        .i_x    (r1_p),
        .i_y    (r1_k5),
        .o_prod (w2_ps)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_op <= r1_op;
            r2_ha <= r1_ha;
            r2_hb <= r1_hb;
            r2_hc <= r1_hc;
            r2_hd <= r1_hd;
            r2_q  <= r1_q;
            r2_k6 <= r1_k6;
        end
    end

    // Stage 3: reduce s and add q.
    logic [W-1:0] n3_s;
    logic         r3_op;
    logic [W-1:0] r3_ha, r3_hb, r3_hc, r3_hd, r3_s, r3_sum, r3_k6;

    assign n3_s = mod_reduce(w2_ps);

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_op  <= r2_op;
            r3_ha  <= r2_ha;
            r3_hb  <= r2_hb;
            r3_hc  <= r2_hc;
            r3_hd  <= r2_hd;
            r3_s   <= n3_s;
            r3_sum <= n3_s + r2_q;
            r3_k6  <= r2_k6;
        end
    end

    // Stage 4: second mixing product.
    logic [ird_pkg::PROD_W-1:0] w4_pt;
    logic         r4_op;
    logic [W-1:0] r4_ha, r4_hb, r4_hc, r4_hd, r4_s;

    ird_mul_stage u_mul_t (
        .i_clk  (i_clk),
        .i_en   (w_adv[4]),
        .i_x    (r3_sum),
        .i_y    (r3_k6),
        .o_prod (w4_pt)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_op <= r3_op;
            r4_ha <= r3_ha;
            r4_hb <= r3_hb;
            r4_hc <= r3_hc;
            r4_hd <= r3_hd;
            r4_s  <= r3_s;
        end
    end

    // Stage 5: reduce t, form u and apply the mixing layer (passed by for the output transformation).
    logic [W-1:0]       n5_t, n5_u;
    ird_pkg::t_out_item n5_out;
    ird_pkg::t_out_item r5_out;

    always_comb begin
        n5_t = mod_reduce(w4_pt);
        n5_u = r4_s + n5_t;
        if (r4_op == ird_pkg::OP_OUTPUT) begin
            n5_out.out_a = r4_ha;
            n5_out.out_b = r4_hb;
            n5_out.out_c = r4_hc;
            n5_out.out_d = r4_hd;
        end else begin
            n5_out.out_a = r4_ha ^ n5_t;
            n5_out.out_b = r4_hb ^ n5_t;
            n5_out.out_c = r4_hc ^ n5_u;
            n5_out.out_d = r4_hd ^ n5_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_out <= n5_out;
        end
    end

    assign o_out_data = r5_out;

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |-> !o_in_stall)
        else $error("input stalled while the pipeline is empty");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ($countones(r_vld) == NSTG && i_out_stall))
        else $error("input stalled with a free stage in the pipeline");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted transfer did not enter the first stage");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-2] && !w_adv[NSTG-1]) |=> r_vld[NSTG-2])
        else $error("block lost while the output stage was held");

endmodule

// File: bench/tb.sv
// Self-checking testbench for the IDEA round datapath with random flow control.
`timescale 1ns / 1ps

module tb;

    localparam int BLOCKS_PER_PHASE = 325;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    class round_scoreboard;
        ird_pkg::t_out_item expected_q[$];
        int errors = 0;
        int rounds = 0;
        int transforms = 0;
        int accepted = 0;
        int checked = 0;

        // Multiplication modulo 65537 where a zero operand stands for 65536.
        static function logic [ird_pkg::WORD_W-1:0] mul_mod(
            logic [ird_pkg::WORD_W-1:0] x, logic [ird_pkg::WORD_W-1:0] y);
            logic [2*ird_pkg::WORD_W+1:0] xv;
            logic [2*ird_pkg::WORD_W+1:0] yv;
            logic [2*ird_pkg::WORD_W+1:0] prod;
            xv = (x == '0) ? 34'h10000 : {18'b0, x};
            yv = (y == '0) ? 34'h10000 : {18'b0, y};
            prod = (xv * yv) % 34'd65537;
            return prod[ird_pkg::WORD_W-1:0];
        endfunction

        function ird_pkg::t_out_item predict_round(ird_pkg::t_in_item blk);
            ird_pkg::t_out_item res;
            logic [ird_pkg::WORD_W-1:0] s;
            logic [ird_pkg::WORD_W-1:0] t;
            logic [ird_pkg::WORD_W-1:0] u;
            res.out_a = mul_mod(blk.word_a, blk.key_mul_first);
            res.out_b = blk.word_c + blk.key_add_second;
            res.out_c = blk.word_b + blk.key_add_third;
            res.out_d = mul_mod(blk.word_d, blk.key_mul_last);
            if (blk.operation == ird_pkg::OP_ROUND) begin
                s = mul_mod(res.out_a ^ res.out_b, blk.key_mix_first);
                t = mul_mod(s + (res.out_c ^ res.out_d), blk.key_mix_second);
                u = s + t;
                res.out_a ^= t;
                res.out_b ^= t;
                res.out_c ^= u;
                res.out_d ^= u;
            end
            return res;
        endfunction

        function void note_block(ird_pkg::t_in_item blk);
            accepted++;
            if (blk.operation == ird_pkg::OP_ROUND) begin
                rounds++;
            end else begin
                transforms++;
            end
            expected_q.push_back(predict_round(blk));
        endfunction

        function void compare_word(string name, logic [ird_pkg::WORD_W-1:0] exp_w,
                                   logic [ird_pkg::WORD_W-1:0] act_w);
            if (act_w !== exp_w) begin
                $error("%s mismatch: expected %h, actual %h", name, exp_w, act_w);
                errors++;
            end
        endfunction

        function void check_result(ird_pkg::t_out_item got);
            ird_pkg::t_out_item exp_item;
            if (expected_q.size() == 0) begin
                $error("Result transfer with no block outstanding: %h", got);
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            checked++;
            compare_word("out_a", exp_item.out_a, got.out_a);
            compare_word("out_b", exp_item.out_b, got.out_b);
            compare_word("out_c", exp_item.out_c, got.out_c);
            compare_word("out_d", exp_item.out_d, got.out_d);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    ird_pkg::t_in_item  in_data = '0;
    logic               in_stall;
    logic               out_valid;
    ird_pkg::t_out_item out_data;
    logic               out_stall = 1'b0;

    round_scoreboard sb = new();
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    idea_round_datapath u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Both channels are sampled here; the watchdog counts cycles without a transfer.
    initial begin
        int quiet_cycles;
        bit moved;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                moved = 1'b0;
                if (in_valid && !in_stall) begin
                    sb.note_block(in_data);
                    moved = 1'b1;
                end
                if (out_valid && !out_stall) begin
                    sb.check_result(out_data);
                    moved = 1'b1;
                end
                quiet_cycles = moved ? 0 : quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog expired with %0d results outstanding.", sb.pending());
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // The receiver holds off once for a long stretch while the sender keeps offering.
    initial begin
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_once && sb.accepted >= 40) begin
                held_once = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    function automatic ird_pkg::t_in_item make_block(logic op, logic [15:0] a,
                                                     logic [15:0] b,
                                                     logic [15:0] c, logic [15:0] d,
                                                     logic [15:0] k1, logic [15:0] k2,
                                                     logic [15:0] k3, logic [15:0] k4,
                                                     logic [15:0] k5, logic [15:0] k6);
        ird_pkg::t_in_item blk;
        blk.operation = op;
        blk.word_a = a;
        blk.word_b = b;
        blk.word_c = c;
        blk.word_d = d;
        blk.key_mul_first = k1;
        blk.key_add_second = k2;
        blk.key_add_third = k3;
        blk.key_mul_last = k4;
        blk.key_mix_first = k5;
        blk.key_mix_second = k6;
        return blk;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(19))
            0, 1:    return 16'h0000;
            2:       return 16'hffff;
            3:       return 16'h0001;
            4:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_block(input ird_pkg::t_in_item blk);
        in_valid <= 1'b1;
        in_data <= blk;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    initial begin
        logic [15:0] ha;
        logic [15:0] hb;
        logic [15:0] s;
        logic [15:0] q;
        int idle_by_phase[4];
        int stall_by_phase[4];
        idle_by_phase = '{0, 68, 0, 24};
        stall_by_phase = '{0, 0, 68, 24};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_block(make_block(ird_pkg::OP_ROUND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_block(make_block(ird_pkg::OP_OUTPUT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_block(make_block(ird_pkg::OP_ROUND, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                              16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_block(make_block(ird_pkg::OP_OUTPUT, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                              16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
        // A zero times zero gives one; one times zero gives 65536, delivered as zero.
        send_block(make_block(ird_pkg::OP_ROUND, 0, 16'h1234, 16'h5678, 1, 0, 16'h9abc,
                              16'hdef0, 0, 16'h0f0f, 16'hf0f0));
        send_block(make_block(ird_pkg::OP_OUTPUT, 1, 16'hffff, 16'hffff, 0, 0, 1, 1, 1,
                              16'h0f0f, 16'hf0f0));
        // The output transformation must ignore the mixing subkeys.
        send_block(make_block(ird_pkg::OP_OUTPUT, 16'h1357, 16'h2468, 16'h369c, 16'h48d1,
                              16'h1111, 16'h2222, 16'h3333, 16'h4444, 0, 0));
        send_block(make_block(ird_pkg::OP_OUTPUT, 16'h1357, 16'h2468, 16'h369c, 16'h48d1,
                              16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'hffff, 16'h8001));
        // Equal first pair gives a zero operand to the first mixing multiplication.
        send_block(make_block(ird_pkg::OP_ROUND, 1, 16'h7777, 1, 16'h3333, 1, 0, 16'h1010,
                              16'h2020, 16'h5a5a, 16'ha5a5));
        send_block(make_block(ird_pkg::OP_ROUND, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_block(make_block(ird_pkg::OP_ROUND, 16'hffff, 16'hffff, 16'h0001, 16'hfffe,
                              16'hffff, 16'hffff, 16'h0001, 16'h0002, 0, 16'hffff));

        // Choose the second pair so that the sum feeding the last multiplication is zero.
        ha = round_scoreboard::mul_mod(16'h1234, 16'h5678);
        hb = 16'h9abc + 16'hdef0;
        s = round_scoreboard::mul_mod(ha ^ hb, 16'h0f0f);
        q = -s;
        send_block(make_block(ird_pkg::OP_ROUND, 16'h1234, (q ^ 16'h0001) - 16'h4321,
                              16'h9abc, 1, 16'h5678, 16'hdef0, 16'h4321, 1, 16'h0f0f,
                              16'h7e57));

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = idle_by_phase[phase];
            receiver_stall_pct = stall_by_phase[phase];
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                pause_sender();
                send_block(make_block(1'($urandom), pick_word(), pick_word(), pick_word(),
                                      pick_word(), pick_word(), pick_word(), pick_word(),
                                      pick_word(), pick_word(), pick_word()));
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d blocks: %0d full rounds, %0d output transformations.",
                 sb.checked, sb.accepted, sb.rounds, sb.transforms);
        $display("%s %s", "Flow control ran free, with sender gaps, receiver stalls, both,",
                 "and one long output hold-off.");
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/ird_pkg.sv
rtl/ird_mul_stage.sv
rtl/idea_round_datapath.sv
bench/tb.sv
